@@ design/xmov_pkg.sv @@
`default_nettype none

package xmov_pkg;

    localparam logic [3:0] MAX_LENGTH = 4'd15;

    localparam logic [7:0] OP_ESCAPE   = 8'h0F;
    localparam logic [7:0] OP_MOV_MR8  = 8'h88;
    localparam logic [7:0] OP_MOV_RM   = 8'h8B;
    localparam logic [7:0] OP_MOV_RM8  = 8'h8A;
    localparam logic [7:0] OP_MOVZX_B  = 8'hB6;
    localparam logic [7:0] OP_MOVZX_W  = 8'hB7;
    localparam logic [7:0] PFX_ADDR    = 8'h67;
    localparam logic [7:0] PFX_OPSZ    = 8'h66;
    localparam logic [7:0] PFX_VEX3    = 8'hC4;
    localparam logic [7:0] PFX_VEX2    = 8'hC5;
    localparam logic [3:0] PFX_REX_HI  = 4'h4;

    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_REG     = 2'd3;
    localparam logic [2:0] RM_SIB      = 3'd4;
    localparam logic [2:0] RM_RIP      = 3'd5;

    localparam logic [2:0] LEGACY_ORDER [8] = '{3'd0, 3'd2, 3'd3, 3'd1,
                                                3'd4, 3'd5, 3'd6, 3'd7};

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_OPCODE,
        PH_MODRM,
        PH_DISP
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_OPCODE,
        ST_BAD_FORM,
        ST_TOO_LONG
    } status_t;

    typedef struct packed {
        logic b;
        logic x;
        logic r;
        logic w;
        logic rex;
        logic opsz;
        logic addr;
    } pflags_t;

    typedef struct packed {
        status_t     status;
        logic        kind;
        logic        mem_is_source;
        logic [6:0]  reg_code;
        logic [3:0]  access_size;
        logic [6:0]  base_code;
        logic [31:0] displacement;
        logic [3:0]  length;
    } result_t;

endpackage

`default_nettype wire

@@ design/xmov_byte_if.sv @@
`default_nettype none

interface xmov_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

`default_nettype wire

@@ design/xmov_result_if.sv @@
`default_nettype none

interface xmov_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               kind;
    logic               mem_is_source;
    logic [6:0]         reg_code;
    logic [3:0]         access_size;
    logic [6:0]         base_code;
    logic signed [31:0] displacement;
    logic [3:0]         length;

    modport source (output valid, output status, output kind, output mem_is_source,
                    output reg_code, output access_size, output base_code,
                    output displacement, output length, input ready);
    modport sink (input valid, input status, input kind, input mem_is_source,
                  input reg_code, input access_size, input base_code,
                  input displacement, input length, output ready);
endinterface

`default_nettype wire

@@ design/xmov_decode_core.sv @@
`default_nettype none

module xmov_decode_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       code_byte,
    output logic                  emit,
    output xmov_pkg::result_t     result
);

    xmov_pkg::phase_t  phase_reg, phase_next;
    xmov_pkg::pflags_t flags_reg, flags_next;
    logic              esc_reg, esc_next;
    logic [7:0]        op_reg, op_next;
    logic [7:0]        modrm_reg, modrm_next;
    logic [31:0]       disp_reg, disp_next;
    logic [2:0]        left_reg, left_next;
    logic [3:0]        count_reg, count_next;

    logic [3:0]        cnt;
    logic              emit_err;
    logic              emit_ok;
    xmov_pkg::status_t err_status;
    logic [3:0]        err_len;

    logic [2:0]        total;
    logic [1:0]        pos;
    logic [31:0]       disp_sum;

    logic [7:0]        mr;
    logic [2:0]        r;
    logic [2:0]        rm;
    logic [1:0]        md;
    logic              byte_op;
    logic [6:0]        rg7;
    logic [6:0]        lo7;
    logic [6:0]        code;
    logic [3:0]        size;
    logic [6:0]        base;
    logic [31:0]       disp;

    always_comb
    begin
        total    = (modrm_reg[7:6] == xmov_pkg::MOD_DISP8) ? 3'd1 : 3'd4;
        pos      = 2'(total - left_reg);
        disp_sum = disp_reg | ({24'd0, code_byte} << {pos, 3'b000});
    end

    always_comb
    begin
        cnt        = count_reg + 4'd1;
        phase_next = phase_reg;
        flags_next = flags_reg;
        esc_next   = esc_reg;
        op_next    = op_reg;
        modrm_next = modrm_reg;
        disp_next  = disp_reg;
        left_next  = left_reg;
        count_next = cnt;
        emit_err   = 1'b0;
        emit_ok    = 1'b0;
        err_status = xmov_pkg::ST_OK;
        err_len    = cnt;

        case (phase_reg)
            xmov_pkg::PH_MODRM:
            begin
                modrm_next = code_byte;
                if (code_byte[7:6] == xmov_pkg::MOD_REG || code_byte[2:0] == xmov_pkg::RM_SIB
                    || code_byte[2:0] == xmov_pkg::RM_RIP)
                begin
                    emit_err   = 1'b1;
                    err_status = xmov_pkg::ST_BAD_FORM;
                end
                else if (code_byte[7:6] == xmov_pkg::MOD_NO_DISP)
                begin
                    emit_ok = 1'b1;
                end
                else
                begin
                    disp_next  = 32'd0;
                    left_next  = (code_byte[7:6] == xmov_pkg::MOD_DISP8) ? 3'd1 : 3'd4;
                    phase_next = xmov_pkg::PH_DISP;
                end
            end
            xmov_pkg::PH_DISP:
            begin
                disp_next = disp_sum;
                left_next = left_reg - 3'd1;
                if (left_next == 3'd0)
                begin
                    emit_ok = 1'b1;
                end
            end
            xmov_pkg::PH_OPCODE:
            begin
                op_next = code_byte;
                if (code_byte == xmov_pkg::OP_MOVZX_B || code_byte == xmov_pkg::OP_MOVZX_W)
                begin
                    phase_next = xmov_pkg::PH_MODRM;
                end
                else
                begin
                    emit_err   = 1'b1;
                    err_status = xmov_pkg::ST_BAD_OPCODE;
                end
            end
            default:
            begin
                if (code_byte inside {xmov_pkg::PFX_ADDR, xmov_pkg::PFX_VEX3,
                                      xmov_pkg::PFX_VEX2})
                begin
                    flags_next.addr = 1'b1;
                end
                else if (code_byte == xmov_pkg::PFX_OPSZ)
                begin
                    flags_next.opsz = 1'b1;
                end
                else if (code_byte[7:4] == xmov_pkg::PFX_REX_HI)
                begin
                    flags_next.rex = 1'b1;
                    flags_next.w   = flags_reg.w | code_byte[3];
                    flags_next.r   = flags_reg.r | code_byte[2];
                    flags_next.x   = flags_reg.x | code_byte[1];
                    flags_next.b   = flags_reg.b | code_byte[0];
                end
                else if (code_byte == xmov_pkg::OP_ESCAPE)
                begin
                    esc_next   = 1'b1;
                    phase_next = xmov_pkg::PH_OPCODE;
                end
                else
                begin
                    op_next = code_byte;
                    if (code_byte inside {[xmov_pkg::OP_MOV_MR8 : xmov_pkg::OP_MOV_RM]})
                    begin
                        phase_next = xmov_pkg::PH_MODRM;
                    end
                    else
                    begin
                        emit_err   = 1'b1;
                        err_status = xmov_pkg::ST_BAD_OPCODE;
                    end
                end
            end
        endcase

        if (!emit_err && !emit_ok && cnt >= xmov_pkg::MAX_LENGTH)
        begin
            emit_err   = 1'b1;
            err_status = xmov_pkg::ST_TOO_LONG;
            err_len    = xmov_pkg::MAX_LENGTH;
        end

        if (emit_err || emit_ok)
        begin
            phase_next = xmov_pkg::PH_PREFIX;
            flags_next = '0;
            esc_next   = 1'b0;
            op_next    = 8'd0;
            modrm_next = 8'd0;
            disp_next  = 32'd0;
            left_next  = 3'd0;
            count_next = 4'd0;
        end
    end

    always_comb
    begin
        mr      = (phase_reg == xmov_pkg::PH_MODRM) ? code_byte : modrm_reg;
        r       = mr[5:3];
        rm      = mr[2:0];
        md      = mr[7:6];
        byte_op = !esc_reg && (op_reg == xmov_pkg::OP_MOV_MR8 || op_reg == xmov_pkg::OP_MOV_RM8);
        rg7     = {4'd0, r};
        lo7     = {4'd0, xmov_pkg::LEGACY_ORDER[r]};

        if (byte_op)
        begin
            size = 4'd1;
            if (flags_reg.r)
                code = 7'd36 + rg7;
            else if (!r[2])
                code = 7'd28 + lo7;
            else if (flags_reg.rex)
                code = 7'd28 + rg7;
            else
                code = 7'd24 + {4'd0, xmov_pkg::LEGACY_ORDER[{1'b0, r[1:0]}]};
        end
        else if (flags_reg.w)
        begin
            size = 4'd8;
            code = flags_reg.r ? 7'd60 + rg7 : lo7;
        end
        else if (flags_reg.opsz)
        begin
            size = 4'd2;
            code = flags_reg.r ? 7'd44 + rg7 : 7'd16 + lo7;
        end
        else
        begin
            size = 4'd4;
            code = flags_reg.r ? 7'd52 + rg7 : 7'd8 + lo7;
        end
        if (esc_reg)
            size = (op_reg == xmov_pkg::OP_MOVZX_B) ? 4'd1 : 4'd2;

        if (flags_reg.b)
            base = (flags_reg.addr ? 7'd52 : 7'd60) + {4'd0, rm};
        else
            base = {4'd0, xmov_pkg::LEGACY_ORDER[rm]} + (flags_reg.addr ? 7'd8 : 7'd0);

        if (md == xmov_pkg::MOD_NO_DISP)
            disp = 32'd0;
        else if (md == xmov_pkg::MOD_DISP8)
            disp = {{24{disp_sum[7]}}, disp_sum[7:0]};
        else
            disp = disp_sum;

        emit = emit_err || emit_ok;
        result = '0;
        if (emit_ok)
        begin
            result.status        = xmov_pkg::ST_OK;
            result.kind          = esc_reg;
            result.mem_is_source = esc_reg || op_reg == xmov_pkg::OP_MOV_RM8
                                   || op_reg == xmov_pkg::OP_MOV_RM;
            result.reg_code      = code;
            result.access_size   = size;
            result.base_code     = base;
            result.displacement  = disp;
            result.length        = cnt;
        end
        else
        begin
            result.status = err_status;
            result.length = err_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= xmov_pkg::PH_PREFIX;
            flags_reg <= '0;
            esc_reg   <= 1'b0;
            op_reg    <= 8'd0;
            modrm_reg <= 8'd0;
            disp_reg  <= 32'd0;
            left_reg  <= 3'd0;
            count_reg <= 4'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            esc_reg   <= esc_next;
            op_reg    <= op_next;
            modrm_reg <= modrm_next;
            disp_reg  <= disp_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/x86_mov_instruction_decoder.sv @@
`default_nettype none

// Byte-serial decoder for x86-64 mov 88/89/8A/8B and movzx 0F B6/B7 with a
// base-only memory operand. One code byte is taken per cycle; each byte passes
// through an input register and then the decode logic, which also updates the
// per-instruction state, so the sustained rate is one byte per cycle and the
// result of an instruction is registered in an output register when its last
// byte is decoded. While a result waits to be taken, no further byte is
// decoded and the input stalls once its register holds a byte. One result item
// comes per instruction, or per failed attempt: bad opcode, rm 4 (SIB), rm 5 or
// register operand forms, or 15 bytes taken without completing the instruction.

module x86_mov_instruction_decoder (
    input  wire logic      clk,
    input  wire logic      rst_n,
    xmov_byte_if.sink      byte_ch,
    xmov_result_if.source  result_ch
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    xmov_pkg::result_t  out_res_reg;

    logic               advance;
    logic               emit;
    xmov_pkg::result_t  result;

    assign advance       = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign byte_ch.ready = !in_valid_reg || advance;

    xmov_decode_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .code_byte (in_byte_reg),
        .emit      (emit),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = emit;
        else if (result_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ch.ready)
                in_valid_reg <= byte_ch.valid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
            in_byte_reg <= byte_ch.code_byte;
        if (advance && emit)
            out_res_reg <= result;
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.status        = out_res_reg.status;
    assign result_ch.kind          = out_res_reg.kind;
    assign result_ch.mem_is_source = out_res_reg.mem_is_source;
    assign result_ch.reg_code      = out_res_reg.reg_code;
    assign result_ch.access_size   = out_res_reg.access_size;
    assign result_ch.base_code     = out_res_reg.base_code;
    assign result_ch.displacement  = $signed(out_res_reg.displacement);
    assign result_ch.length        = out_res_reg.length;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam logic [7:0] OP_MOV_MR   = xmov_pkg::OP_MOV_MR8 + 8'd1;
    localparam logic [7:0] OP_MOV_IMM  = 8'hC7;
    localparam logic [1:0] MOD_DISP32  = 2'd2;
    localparam logic [7:0] REX_PLAIN   = {xmov_pkg::PFX_REX_HI, 4'h0};
    localparam logic [7:0] REX_WRXB    = {xmov_pkg::PFX_REX_HI, 4'hF};
    localparam int         HOLD_CYCLES = 300;
    localparam int         RANDOM_BYTES = 1300;
    localparam int         MAX_REPORTS = 10;

    class mov_decode_checker;
        xmov_pkg::phase_t  dec_phase;
        xmov_pkg::pflags_t pfx;
        logic              escaped;
        logic [7:0]        opcode;
        logic [7:0]        modrm;
        logic [31:0]       disp_acc;
        logic [2:0]        disp_left;
        logic [3:0]        count;
        xmov_pkg::result_t expected_decodes[$];
        int                error_count;

        function new();
            clear_instr();
            error_count = 0;
        endfunction

        function void clear_instr();
            dec_phase = xmov_pkg::PH_PREFIX;
            pfx       = '0;
            escaped   = 1'b0;
            opcode    = '0;
            modrm     = '0;
            disp_acc  = '0;
            disp_left = '0;
            count     = '0;
        endfunction

        function void push_fault(xmov_pkg::status_t st, logic [3:0] len);
            xmov_pkg::result_t r;
            r        = '0;
            r.status = st;
            r.length = len;
            expected_decodes.push_back(r);
            clear_instr();
        endfunction

        function void push_decoded(logic [3:0] len);
            xmov_pkg::result_t r;
            logic [2:0]        reg_f;
            logic [2:0]        rm_f;
            logic [1:0]        mod_f;
            logic              zx;
            logic              byte_op;
            logic [6:0]        code;
            logic [6:0]        base;
            logic [3:0]        size;
            reg_f   = modrm[5:3];
            rm_f    = modrm[2:0];
            mod_f   = modrm[7:6];
            zx      = escaped;
            byte_op = !zx && (opcode == xmov_pkg::OP_MOV_MR8 || opcode == xmov_pkg::OP_MOV_RM8);
            if (byte_op)
            begin
                size = 4'd1;
                if (pfx.r)
                    code = 7'd36 + 7'(reg_f);
                else if (reg_f < 3'd4)
                    code = 7'd28 + 7'(xmov_pkg::LEGACY_ORDER[reg_f]);
                else if (pfx.rex)
                    code = 7'd32 + 7'(reg_f - 3'd4);
                else
                    code = 7'd24 + 7'(xmov_pkg::LEGACY_ORDER[reg_f - 3'd4]);
            end
            else if (pfx.w)
            begin
                size = 4'd8;
                code = pfx.r ? 7'd60 + 7'(reg_f) : 7'(xmov_pkg::LEGACY_ORDER[reg_f]);
            end
            else if (pfx.opsz)
            begin
                size = 4'd2;
                code = pfx.r ? 7'd44 + 7'(reg_f)
                             : 7'd16 + 7'(xmov_pkg::LEGACY_ORDER[reg_f]);
            end
            else
            begin
                size = 4'd4;
                code = pfx.r ? 7'd52 + 7'(reg_f)
                             : 7'd8 + 7'(xmov_pkg::LEGACY_ORDER[reg_f]);
            end
            if (zx)
                size = (opcode == xmov_pkg::OP_MOVZX_B) ? 4'd1 : 4'd2;
            if (pfx.b)
                base = (pfx.addr ? 7'd52 : 7'd60) + 7'(rm_f);
            else
                base = 7'(xmov_pkg::LEGACY_ORDER[rm_f]) + (pfx.addr ? 7'd8 : 7'd0);
            r.status        = xmov_pkg::ST_OK;
            r.kind          = zx;
            r.mem_is_source = zx || opcode == xmov_pkg::OP_MOV_RM8
                              || opcode == xmov_pkg::OP_MOV_RM;
            r.reg_code      = code;
            r.access_size   = size;
            r.base_code     = base;
            if (mod_f == xmov_pkg::MOD_NO_DISP)
                r.displacement = '0;
            else if (mod_f == xmov_pkg::MOD_DISP8)
                r.displacement = {{24{disp_acc[7]}}, disp_acc[7:0]};
            else
                r.displacement = disp_acc;
            r.length = len;
            expected_decodes.push_back(r);
            clear_instr();
        endfunction

        function void predict_byte(logic [7:0] cb);
            logic [3:0] cnt;
            logic       emitted;
            int         total;
            int         pos;
            cnt     = count + 4'd1;
            emitted = 1'b0;
            case (dec_phase)
                xmov_pkg::PH_MODRM:
                begin
                    modrm = cb;
                    if (cb[7:6] == xmov_pkg::MOD_REG || cb[2:0] == xmov_pkg::RM_SIB
                        || cb[2:0] == xmov_pkg::RM_RIP)
                    begin
                        push_fault(xmov_pkg::ST_BAD_FORM, cnt);
                        emitted = 1'b1;
                    end
                    else if (cb[7:6] == xmov_pkg::MOD_NO_DISP)
                    begin
                        push_decoded(cnt);
                        emitted = 1'b1;
                    end
                    else
                    begin
                        disp_acc  = '0;
                        disp_left = (cb[7:6] == xmov_pkg::MOD_DISP8) ? 3'd1 : 3'd4;
                        dec_phase = xmov_pkg::PH_DISP;
                    end
                end
                xmov_pkg::PH_DISP:
                begin
                    total     = (modrm[7:6] == xmov_pkg::MOD_DISP8) ? 1 : 4;
                    pos       = total - int'(disp_left);
                    disp_acc  = disp_acc | (32'(cb) << (8 * pos));
                    disp_left = disp_left - 3'd1;
                    if (disp_left == 3'd0)
                    begin
                        push_decoded(cnt);
                        emitted = 1'b1;
                    end
                end
                xmov_pkg::PH_OPCODE:
                begin
                    opcode = cb;
                    if (cb != xmov_pkg::OP_MOVZX_B && cb != xmov_pkg::OP_MOVZX_W)
                    begin
                        push_fault(xmov_pkg::ST_BAD_OPCODE, cnt);
                        emitted = 1'b1;
                    end
                    else
                        dec_phase = xmov_pkg::PH_MODRM;
                end
                default:
                begin
                    if (cb == xmov_pkg::PFX_ADDR || cb == xmov_pkg::PFX_VEX3
                        || cb == xmov_pkg::PFX_VEX2)
                        pfx.addr = 1'b1;
                    else if (cb == xmov_pkg::PFX_OPSZ)
                        pfx.opsz = 1'b1;
                    else if (cb[7:4] == xmov_pkg::PFX_REX_HI)
                    begin
                        pfx.rex = 1'b1;
                        pfx.w   = pfx.w | cb[3];
                        pfx.r   = pfx.r | cb[2];
                        pfx.x   = pfx.x | cb[1];
                        pfx.b   = pfx.b | cb[0];
                    end
                    else if (cb == xmov_pkg::OP_ESCAPE)
                    begin
                        escaped   = 1'b1;
                        dec_phase = xmov_pkg::PH_OPCODE;
                    end
                    else
                    begin
                        opcode = cb;
                        if (cb < xmov_pkg::OP_MOV_MR8 || cb > xmov_pkg::OP_MOV_RM)
                        begin
                            push_fault(xmov_pkg::ST_BAD_OPCODE, cnt);
                            emitted = 1'b1;
                        end
                        else
                            dec_phase = xmov_pkg::PH_MODRM;
                    end
                end
            endcase
            if (!emitted)
            begin
                if (cnt >= xmov_pkg::MAX_LENGTH)
                    push_fault(xmov_pkg::ST_TOO_LONG, xmov_pkg::MAX_LENGTH);
                else
                    count = cnt;
            end
        endfunction

        function string describe(xmov_pkg::result_t r);
            return $sformatf({"status=%0d kind=%0d src=%0d reg=%0d size=%0d",
                              " base=%0d disp=%h len=%0d"},
                             r.status, r.kind, r.mem_is_source, r.reg_code, r.access_size,
                             r.base_code, r.displacement, r.length);
        endfunction

        function void check_decode(xmov_pkg::result_t got);
            xmov_pkg::result_t want;
            if (expected_decodes.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result: %s", $realtime, describe(got));
                return;
            end
            want = expected_decodes.pop_front();
            if (got.status !== want.status || got.kind !== want.kind
                || got.mem_is_source !== want.mem_is_source
                || got.reg_code !== want.reg_code || got.access_size !== want.access_size
                || got.base_code !== want.base_code
                || got.displacement !== want.displacement
                || got.length !== want.length)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch", $realtime);
                    $display("    expected: %s", describe(want));
                    $display("    actual:   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    xmov_byte_if   byte_ch();
    xmov_result_if result_ch();

    x86_mov_instruction_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    mov_decode_checker decoder_sb = new();
    int tx_pct;
    int rx_pct;
    int sent_count;
    bit rx_hold_request;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] rand_prefix();
        case ($urandom_range(4))
            0:       return xmov_pkg::PFX_OPSZ;
            1:       return xmov_pkg::PFX_ADDR;
            2:       return xmov_pkg::PFX_VEX3;
            3:       return xmov_pkg::PFX_VEX2;
            default: return {xmov_pkg::PFX_REX_HI, 4'($urandom_range(15))};
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] cb);
        int gap;
        gap = pick_gap(tx_pct);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.code_byte <= cb;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        decoder_sb.predict_byte(cb);
        sent_count++;
    endtask

    task automatic send_mov(input int npfx, input bit bad_form);
        logic [1:0] mod_f;
        logic [2:0] rm_f;
        logic [7:0] modrm_b;
        repeat (npfx) send_byte(rand_prefix());
        if ($urandom_range(3) == 0)
        begin
            send_byte(xmov_pkg::OP_ESCAPE);
            send_byte($urandom_range(1) ? xmov_pkg::OP_MOVZX_W : xmov_pkg::OP_MOVZX_B);
        end
        else
            send_byte(xmov_pkg::OP_MOV_MR8 + 8'($urandom_range(3)));
        mod_f = 2'($urandom_range(2));
        rm_f  = 3'($urandom_range(5));
        if (rm_f >= xmov_pkg::RM_SIB)
            rm_f = rm_f + 3'd2;
        modrm_b = {mod_f, 3'($urandom_range(7)), rm_f};
        if (bad_form)
        begin
            case ($urandom_range(2))
                0:       modrm_b[7:6] = xmov_pkg::MOD_REG;
                1:       modrm_b[2:0] = xmov_pkg::RM_SIB;
                default: modrm_b[2:0] = xmov_pkg::RM_RIP;
            endcase
        end
        send_byte(modrm_b);
        if (!bad_form && mod_f == xmov_pkg::MOD_DISP8)
            send_byte(8'($urandom));
        else if (!bad_form && mod_f == MOD_DISP32)
            repeat (4) send_byte(8'($urandom));
    endtask

    task automatic send_random_instr();
        int sel;
        sel = $urandom_range(99);
        if (sel < 78)
            send_mov($urandom_range(3), 1'b0);
        else if (sel < 87)
            send_mov($urandom_range(2), 1'b1);
        else if (sel < 93)
            send_mov($urandom_range(8, 14), 1'b0);
        else
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    endtask

    task automatic drain_results();
        do
            @(posedge clk);
        while (decoder_sb.expected_decodes.size() != 0);
    endtask

    initial
    begin
        xmov_pkg::result_t got;
        int                stall_left;
        result_ch.ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.status        = xmov_pkg::status_t'(result_ch.status);
                got.kind          = result_ch.kind;
                got.mem_is_source = result_ch.mem_is_source;
                got.reg_code      = result_ch.reg_code;
                got.access_size   = result_ch.access_size;
                got.base_code     = result_ch.base_code;
                got.displacement  = result_ch.displacement;
                got.length        = result_ch.length;
                decoder_sb.check_decode(got);
            end
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                stall_left      = HOLD_CYCLES;
            end
            else if (stall_left == 0)
                stall_left = pick_gap(rx_pct);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        logic [7:0] directed[$];
        int         pressure_done;
        int         burst_end;
        directed = '{
            xmov_pkg::OP_MOV_RM, {xmov_pkg::MOD_NO_DISP, 3'd0, 3'd0},
            xmov_pkg::OP_MOV_MR8, {xmov_pkg::MOD_DISP8, 3'd0, 3'd1}, 8'h80,
            xmov_pkg::PFX_OPSZ, xmov_pkg::PFX_ADDR, REX_WRXB, OP_MOV_MR,
            {MOD_DISP32, 3'd7, 3'd7},
            8'hFF, 8'hFF, 8'hFF, 8'hFF,
            xmov_pkg::PFX_VEX2, xmov_pkg::OP_ESCAPE, xmov_pkg::OP_MOVZX_B,
            {xmov_pkg::MOD_NO_DISP, 3'd4, 3'd3},
            REX_PLAIN, xmov_pkg::OP_MOV_RM8, {xmov_pkg::MOD_DISP8, 3'd6, 3'd6}, 8'h7F,
            xmov_pkg::OP_MOV_RM8, {xmov_pkg::MOD_NO_DISP, 3'd5, 3'd2},
            xmov_pkg::PFX_OPSZ, xmov_pkg::OP_ESCAPE, xmov_pkg::OP_MOVZX_W,
            {MOD_DISP32, 3'd2, 3'd0},
            8'h00, 8'h00, 8'h00, 8'h80,
            xmov_pkg::OP_MOV_RM8, {xmov_pkg::MOD_DISP8, 3'd1, xmov_pkg::RM_SIB},
            xmov_pkg::OP_MOV_RM, {xmov_pkg::MOD_REG, 3'd0, 3'd0},
            xmov_pkg::OP_MOV_RM, {xmov_pkg::MOD_NO_DISP, 3'd0, xmov_pkg::RM_RIP},
            OP_MOV_IMM,
            xmov_pkg::OP_ESCAPE, xmov_pkg::OP_ESCAPE,
            xmov_pkg::OP_ESCAPE, xmov_pkg::PFX_OPSZ
        };
        rst_n               <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.code_byte   <= '0;
        tx_pct          = 0;
        rx_pct          = 0;
        sent_count      = 0;
        rx_hold_request = 1'b0;
        pressure_done   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_byte(directed[i]);
        repeat (xmov_pkg::MAX_LENGTH) send_byte(xmov_pkg::PFX_VEX3);
        byte_ch.valid <= 1'b0;
        drain_results();

        sent_count = 0;
        while (sent_count < RANDOM_BYTES)
        begin
            if ($urandom_range(39) == 0)
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        tx_pct = 0;
                        rx_pct = 0;
                    end
                    1:
                    begin
                        tx_pct = 20;
                        rx_pct = 20;
                    end
                    default:
                    begin
                        tx_pct = 60;
                        rx_pct = 50;
                    end
                endcase
            end
            if (!pressure_done && sent_count > RANDOM_BYTES / 3)
            begin
                pressure_done   = 1;
                tx_pct          = 0;
                rx_hold_request = 1'b1;
                burst_end       = sent_count + 120;
                while (sent_count < burst_end)
                    send_random_instr();
                byte_ch.valid <= 1'b0;
                drain_results();
            end
            send_random_instr();
        end
        byte_ch.valid <= 1'b0;

        drain_results();
        repeat (20) @(posedge clk);
        if (decoder_sb.error_count == 0 && decoder_sb.expected_decodes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
